[src/acr_pkg.sv]
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constants of the curved-linear resampler
// Request and response payloads, pipeline tags, frame history and
// register indexes used by all modules of the block.
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int STEP_W     = 24;
   localparam int POS_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO       = 2'd2;

   localparam logic [1:0]        SB_EIGHT_BIT = 2'd1;
   localparam logic [STEP_W-1:0] STEP_RESET   = 24'd65536;
   localparam logic [1:0]        SB_RESET     = 2'd2;
   localparam logic              STEREO_RESET = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } acr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       last_of_run;
   } acr_rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
   } acr_tag_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] a_l;
      logic signed [SAMPLE_W-1:0] b_l;
      logic signed [SAMPLE_W-1:0] c_l;
      logic signed [SAMPLE_W-1:0] a_r;
      logic signed [SAMPLE_W-1:0] b_r;
      logic signed [SAMPLE_W-1:0] c_r;
   } acr_hist_type;

endpackage

[src/acr_seq.sv]
// ----------------------------------------------------------------------------
// acr_seq: frame intake and output position sequencer
// Takes requests, keeps the three-frame history and steps the output
// position, issuing one fraction per cycle into the pipeline while advance is high.
// ----------------------------------------------------------------------------
module acr_seq #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_RUN   = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  acr_pkg::acr_req_type           req_data,
   input  logic [acr_pkg::STEP_W-1:0]     phase_step,
   input  logic                           sample8,
   input  logic                           stereo,
   input  logic                           pipe_empty,
   input  logic                           advance,
   output acr_pkg::acr_tag_type           tag,
   output logic [FRAC_BITS-1:0]           frac,
   output acr_pkg::acr_hist_type          hist
);
   import acr_pkg::*;

   localparam int CNT_W = $clog2(MAX_RUN);
   localparam logic [POS_W:0] ONE = {{POS_W{1'b0}}, 1'b1} << FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  seen_ff, seen_in;
   acr_hist_type          hist_ff, hist_in;
   acr_tag_type           tag_ff, tag_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;

   logic signed [SAMPLE_W-1:0] cl, cr;
   logic [POS_W:0]        pos_ext, pos_next;
   logic                  is_last, accept;

   function automatic logic signed [SAMPLE_W-1:0] take_sample(
      input logic signed [SAMPLE_W-1:0] v, input logic eight);
      if (eight) begin
         return {8'd0, v[7:0]};
      end
      return v;
   endfunction

   always_comb begin
      cl        = take_sample(req_data.left_sample, sample8);
      cr        = stereo ? take_sample(req_data.right_sample, sample8) : cl;
      pos_ext   = {1'b0, pos_ff};
      pos_next  = pos_ext + {1'b0, phase_step};
      is_last   = (pos_next >= ONE) || (cnt_ff == CNT_W'(MAX_RUN - 1));
      req_ready = (state_ff == ST_IDLE) && pipe_empty;
      accept    = req_valid && req_ready;

      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      seen_in  = seen_ff;
      hist_in  = hist_ff;
      tag_in   = tag_ff;
      frac_in  = frac_ff;
      if (advance) begin
         tag_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!seen_ff) begin
                  seen_in = 1'b1;
                  hist_in = '{a_l: cl, b_l: cl, c_l: cl, a_r: cr, b_r: cr, c_r: cr};
               end else begin
                  hist_in = '{a_l: hist_ff.b_l, b_l: hist_ff.c_l, c_l: cl,
                              a_r: hist_ff.b_r, b_r: hist_ff.c_r, c_r: cr};
                  if (pos_ext >= ONE) begin
                     pos_in = POS_W'(pos_ext - ONE);
                  end else begin
                     state_in = ST_RUN;
                     cnt_in   = '0;
                  end
               end
            end
         end
         ST_RUN: begin
            if (advance) begin
               tag_in  = '{valid: 1'b1, last: is_last};
               frac_in = pos_ff[FRAC_BITS-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
                  pos_in   = (pos_next >= ONE) ? POS_W'(pos_next - ONE) : '0;
               end else begin
                  pos_in = POS_W'(pos_next);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         seen_ff  <= 1'b0;
         hist_ff  <= '0;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         seen_ff  <= seen_in;
         hist_ff  <= hist_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
   end

   assign tag  = tag_ff;
   assign frac = frac_ff;
   assign hist = hist_ff;

endmodule

[src/acr_frac.sv]
// ----------------------------------------------------------------------------
// acr_frac: curvature weight stage
// Computes the shared weight fr*(1-fr)/2 once per output for both lanes.
// ----------------------------------------------------------------------------
module acr_frac #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  acr_pkg::acr_tag_type  src_tag,
   input  logic [FRAC_BITS-1:0]  src_frac,
   output acr_pkg::acr_tag_type  dst_tag,
   output logic [FRAC_BITS-1:0]  dst_frac,
   output logic [FRAC_BITS-1:0]  dst_weight
);
   import acr_pkg::*;

   localparam logic [FRAC_BITS:0] ONE = {{FRAC_BITS{1'b0}}, 1'b1} << FRAC_BITS;

   acr_tag_type               tag_ff;
   logic [FRAC_BITS-1:0]      frac_ff;
   logic [FRAC_BITS-1:0]      weight_ff;
   logic [FRAC_BITS:0]        frac_ext, rest;
   logic [2*FRAC_BITS+1:0]    prod;

   always_comb begin
      frac_ext = {1'b0, src_frac};
      rest     = ONE - frac_ext;
      prod     = (2*FRAC_BITS+2)'(frac_ext) * (2*FRAC_BITS+2)'(rest);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= src_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         frac_ff   <= src_frac;
         weight_ff <= prod[2*FRAC_BITS:FRAC_BITS+1];
      end
   end

   assign dst_tag    = tag_ff;
   assign dst_frac   = frac_ff;
   assign dst_weight = weight_ff;

endmodule

[src/acr_lane.sv]
// ----------------------------------------------------------------------------
// acr_lane: one channel of the interpolator
// Forms b + (c-b)*fr - k*f over two registered stages, then scales,
// truncates toward zero and saturates to 16 bits.
// ----------------------------------------------------------------------------
module acr_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic                                  sample8,
   input  logic signed [acr_pkg::SAMPLE_W-1:0]   a,
   input  logic signed [acr_pkg::SAMPLE_W-1:0]   b,
   input  logic signed [acr_pkg::SAMPLE_W-1:0]   c,
   input  logic [FRAC_BITS-1:0]                  frac,
   input  logic [FRAC_BITS-1:0]                  weight,
   output logic signed [acr_pkg::SAMPLE_W-1:0]   result
);
   import acr_pkg::*;

   localparam int P1_W = FRAC_BITS + 18;
   localparam int P2_W = FRAC_BITS + 19;
   localparam int QW   = FRAC_BITS + 20;
   localparam int SW   = QW + 9;
   localparam int RW   = SW - FRAC_BITS;
   localparam logic signed [SW-1:0] BIAS = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS + 15);
   localparam logic signed [SW-1:0] RND  = (({{(SW-1){1'b0}}, 1'b1}) << FRAC_BITS) - 1'b1;

   logic signed [16:0]          diff;
   logic signed [17:0]          curve;
   logic signed [FRAC_BITS:0]   frac_s, weight_s;
   logic signed [P1_W-1:0]      p1_ff, p1_in;
   logic signed [P2_W-1:0]      p2_ff, p2_in;
   logic signed [QW-1:0]        q_ff, q_in;
   logic signed [FRAC_BITS+15:0] b_sh;
   logic signed [SW-1:0]        scaled, biased;
   logic signed [RW-1:0]        quot;

   always_comb begin
      diff     = 17'(c) - 17'(b);
      curve    = 18'(c) - (18'(b) <<< 1) + 18'(a);
      frac_s   = {1'b0, frac};
      weight_s = {1'b0, weight};
      p1_in    = P1_W'(diff) * P1_W'(frac_s);
      p2_in    = P2_W'(curve) * P2_W'(weight_s);
      b_sh     = {b, {FRAC_BITS{1'b0}}};
      q_in     = QW'(b_sh) + QW'(p1_ff) - QW'(p2_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         q_ff  <= q_in;
      end
   end

   always_comb begin
      scaled = sample8 ? ((SW'(q_ff) <<< 8) - BIAS) : SW'(q_ff);
      biased = scaled + (scaled[SW-1] ? RND : '0);
      quot   = biased[SW-1:FRAC_BITS];
      if (quot > RW'(SAT_MAX)) begin
         result = SAT_MAX;
      end else if (quot < RW'(SAT_MIN)) begin
         result = SAT_MIN;
      end else begin
         result = quot[SAMPLE_W-1:0];
      end
   end

endmodule

[src/audio_curved_linear_resampler.sv]
// ----------------------------------------------------------------------------
// audio_curved_linear_resampler: curved-linear audio sample rate converter
// Each request carries one frame; it yields zero to MAX_RUN responses.
// Path: each response passes the sequencer, weight stage, lane stages and output register.
// Throughput: one response per cycle while rsp_ready holds; the next request is taken
// once the last response of the frame has left the four-stage tag pipeline of sequencer,
// weight and lane stages ahead of the output register.
// Reset: registers return to 65536 / 2 / stereo, history and position clear.
// ----------------------------------------------------------------------------
module audio_curved_linear_resampler #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_RUN   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  acr_pkg::acr_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output acr_pkg::acr_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [acr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import acr_pkg::*;

   logic [STEP_W-1:0]    phase_step_ff;
   logic [1:0]           sample_bytes_ff;
   logic                 stereo_ff;
   logic                 sample8, advance, pipe_empty;

   acr_tag_type          tag0, tag1, tag2_ff, tag3_ff;
   logic [FRAC_BITS-1:0] frac0, frac1, weight1;
   acr_hist_type         hist;
   logic signed [SAMPLE_W-1:0] left_res, right_res;

   logic                 rsp_valid_ff;
   acr_rsp_type          rsp_data_ff;

   assign csr_ready  = 1'b1;
   assign sample8    = (sample_bytes_ff == SB_EIGHT_BIT);
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign pipe_empty = !tag0.valid && !tag1.valid && !tag2_ff.valid && !tag3_ff.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= STEP_RESET;
         sample_bytes_ff <= SB_RESET;
         stereo_ff       <= STEREO_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PHASE_STEP:   phase_step_ff   <= csr_data[STEP_W-1:0];
            CSR_SAMPLE_BYTES: sample_bytes_ff <= csr_data[1:0];
            CSR_STEREO:       stereo_ff       <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   acr_seq #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_RUN   (MAX_RUN)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .phase_step (phase_step_ff),
      .sample8    (sample8),
      .stereo     (stereo_ff),
      .pipe_empty (pipe_empty),
      .advance    (advance),
      .tag        (tag0),
      .frac       (frac0),
      .hist       (hist)
   );

   acr_frac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_frac (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .src_tag    (tag0),
      .src_frac   (frac0),
      .dst_tag    (tag1),
      .dst_frac   (frac1),
      .dst_weight (weight1)
   );

   acr_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_left (
      .clock   (clock),
      .advance (advance),
      .sample8 (sample8),
      .a       (hist.a_l),
      .b       (hist.b_l),
      .c       (hist.c_l),
      .frac    (frac1),
      .weight  (weight1),
      .result  (left_res)
   );

   acr_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_right (
      .clock   (clock),
      .advance (advance),
      .sample8 (sample8),
      .a       (hist.a_r),
      .b       (hist.b_r),
      .c       (hist.c_r),
      .frac    (frac1),
      .weight  (weight1),
      .result  (right_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         tag2_ff      <= tag1;
         tag3_ff      <= tag2_ff;
         rsp_valid_ff <= tag3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tag3_ff.valid) begin
         rsp_data_ff <= '{left_out: left_res, right_out: right_res,
                          last_of_run: tag3_ff.last};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The last response of a frame is never followed by another in flight.
   assert property (@(posedge clock) disable iff (reset)
      (tag3_ff.valid && tag3_ff.last) |-> (!tag0.valid && !tag1.valid && !tag2_ff.valid))
      else $error("response in flight behind the last of its frame");

   // A response that is not the last of its frame is always followed by another.
   assert property (@(posedge clock) disable iff (reset)
      (tag0.valid && !tag0.last) |=> tag0.valid)
      else $error("frame run ended without a last marker");

   // No frame is taken while responses are still in the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !tag1.valid && !tag2_ff.valid && !tag3_ff.valid)
      else $error("request accepted while the pipeline was busy");

endmodule
